### src/sle_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted list engine: value type, command and status codes,
// and the control bundle that the top level broadcasts to every cell. No dependencies.
package sle_pkg;

   typedef logic signed [31:0] sle_value_type;

   typedef logic [1:0] sle_code_type;

   localparam sle_code_type CMD_INSERT = 2'd0;
   localparam sle_code_type CMD_SEARCH = 2'd1;
   localparam sle_code_type CMD_DELETE = 2'd2;
   localparam sle_code_type CMD_POP    = 2'd3;

   localparam sle_code_type STAT_OK        = 2'd0;
   localparam sle_code_type STAT_NOT_FOUND = 2'd1;
   localparam sle_code_type STAT_FULL      = 2'd2;
   localparam sle_code_type STAT_EMPTY     = 2'd3;

   typedef struct packed {
      logic cmp_en;
      logic ins_en;
      logic rem_en;
      logic rem_all;
   } sle_ctrl_type;

endpackage

### src/sorted_list_engine.sv
`timescale 1ns / 1ps
// Top level of the sorted list engine: command sequencer, output register
// and the row of sle_cell entries. Depends on sle_pkg and sle_cell.
//
//   Channel | Ports                                          | Direction
//   request | req_valid, req_stall, req_command, req_operand_value | in
//   result  | rsp_valid, rsp_stall, rsp_status, rsp_popped_value, rsp_entry_count | out
//
// In each transfer every cell first compares its entry with the key as the request
// is accepted; then, in the execute state, the cells shift and the result register loads.
// A new request is taken once the previous one has been written to the result register.
// Reset empties the list at once; entries are never cleared.
// A stalled result holds the execute state until the result register frees.
module sorted_list_engine
   import sle_pkg::*;
#(
   parameter int CAPACITY = 64,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_command,
   input  sle_value_type req_operand_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output sle_value_type rsp_popped_value,
   output logic [CW-1:0] rsp_entry_count
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   sle_code_type  cmd_ff, cmd_in;
   sle_value_type key_ff, key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sle_code_type  status_ff, status_in;
   sle_value_type popped_ff, popped_in;
   logic [CW-1:0] rcount_ff, rcount_in;

   sle_ctrl_type  ctrl;
   sle_value_type val [CAPACITY];
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] hit_vec;
   logic          accept, out_free, done, found, full, empty;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign req_stall = state_ff != ST_IDLE;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign done     = (state_ff == ST_EXEC) && out_free;
   assign found    = |hit_vec;
   assign full     = count_ff == CW'(CAPACITY);
   assign empty    = count_ff == '0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         sle_value_type lv, rv;
         logic          llt;
         if (gi == 0) begin : g_first
            assign lv  = key_ff;
            assign llt = 1'b1;
         end else begin : g_mid
            assign lv  = val[gi-1];
            assign llt = lt_vec[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign rv = val[gi];
         end else begin : g_inner
            assign rv = val[gi+1];
         end
         sle_cell #(.INDEX(gi), .CW(CW)) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .key       (key_in),
            .count     (count_ff),
            .left_val  (lv),
            .left_lt   (llt),
            .right_val (rv),
            .val       (val[gi]),
            .lt        (lt_vec[gi]),
            .hit       (hit_vec[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      popped_in    = popped_ff;
      rcount_in    = rcount_ff;
      ctrl         = '0;
      ctrl.cmp_en  = accept;
      if (accept) begin
         cmd_in   = req_command;
         key_in   = req_operand_value;
         state_in = ST_EXEC;
      end
      if (done) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         status_in    = STAT_OK;
         popped_in    = '0;
         case (cmd_ff)
            CMD_INSERT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  ctrl.ins_en = 1'b1;
                  count_in    = count_ff + 1'b1;
               end
            end
            CMD_SEARCH: begin
               if (!found) begin
                  status_in = STAT_NOT_FOUND;
               end
            end
            CMD_DELETE: begin
               if (!found) begin
                  status_in = STAT_NOT_FOUND;
               end else begin
                  ctrl.rem_en = 1'b1;
                  count_in    = count_ff - 1'b1;
               end
            end
            CMD_POP: begin
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  ctrl.rem_en  = 1'b1;
                  ctrl.rem_all = 1'b1;
                  popped_in    = val[0];
                  count_in     = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = STAT_NOT_FOUND;
            end
         endcase
         rcount_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
      rcount_ff <= rcount_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_entry_count  = rcount_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> $onehot0(hit_vec))
      else $error("more than one cell claims the first match");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      done && cmd_ff == CMD_INSERT && full |=> count_ff == $past(count_ff))
      else $error("insert on a full list changed the count");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STAT_OK |-> popped_ff == '0)
      else $error("failed command returned a nonzero popped value");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_entry_count == count_ff)
      else $error("reported count differs from held count");

endmodule

### src/sle_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted list: holds one entry and its compare flags,
// and takes its neighbor's entry on insert or removal. Depends on sle_pkg.
module sle_cell
   import sle_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  logic          clock,
   input  sle_ctrl_type  ctrl,
   input  sle_value_type key,
   input  logic [CW-1:0] count,
   input  sle_value_type left_val,
   input  logic          left_lt,
   input  sle_value_type right_val,
   output sle_value_type val,
   output logic          lt,
   output logic          hit
);

   sle_value_type entry_ff, entry_in;
   logic          lt_ff, lt_in;
   logic          eq_ff, eq_in;
   logic          occ;

   assign occ = CW'(INDEX) < count;

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctrl.cmp_en) begin
         lt_in = occ && (entry_ff < key);
         eq_in = occ && (entry_ff == key);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (!lt_ff) begin
            entry_in = left_lt ? key : left_val;
         end
      end else if (ctrl.rem_en) begin
         if (ctrl.rem_all || !lt_ff) begin
            entry_in = right_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign val = entry_ff;
   assign lt  = lt_ff;
   assign hit = eq_ff && left_lt;

endmodule

### test/tb_sorted_list_engine.sv
`timescale 1ns / 1ps
// Testbench for sorted_list_engine: drives random insert, search, delete and pop transfers
// and checks every result against a queue-based model of the sorted list.
// Depends on sle_pkg and the sorted_list_engine RTL.
module tb_sorted_list_engine;
   import sle_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam sle_value_type VALUE_MIN = 32'sh8000_0000;
   localparam sle_value_type VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      sle_code_type  status;
      sle_value_type popped;
      int            count;
   } list_outcome_type;

   class sorted_list_scoreboard;
      sle_value_type    held[$];
      list_outcome_type awaited[$];
      int               errors = 0;

      function void note_request(sle_code_type cmd, sle_value_type val);
         list_outcome_type outcome;
         int pos;
         outcome.status = STAT_OK;
         outcome.popped = '0;
         pos = 0;
         while (pos < held.size() && held[pos] < val) pos++;
         case (cmd)
            CMD_INSERT: begin
               if (held.size() >= LIST_DEPTH) outcome.status = STAT_FULL;
               else held.insert(pos, val);
            end
            CMD_SEARCH, CMD_DELETE: begin
               if (pos >= held.size() || held[pos] != val) outcome.status = STAT_NOT_FOUND;
               else if (cmd == CMD_DELETE) held.delete(pos);
            end
            default: begin
               if (held.size() == 0) outcome.status = STAT_EMPTY;
               else outcome.popped = held.pop_front();
            end
         endcase
         outcome.count = held.size();
         awaited.push_back(outcome);
      endfunction

      function void check_result(sle_code_type status, sle_value_type popped, int count);
         list_outcome_type outcome;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result status %0d popped %0d count %0d",
                     $time, status, popped, count);
            errors++;
            return;
         end
         outcome = awaited.pop_front();
         if (status != outcome.status) begin
            $display("%0t: status expected %0d actual %0d", $time, outcome.status, status);
            errors++;
         end
         if (popped != outcome.popped) begin
            $display("%0t: popped_value expected %0d actual %0d", $time, outcome.popped,
                     popped);
            errors++;
         end
         if (count != outcome.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, outcome.count, count);
            errors++;
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [1:0]    req_command;
   sle_value_type req_operand_value;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [1:0]    rsp_status;
   sle_value_type rsp_popped_value;
   logic [CW-1:0] rsp_entry_count;
   logic          quiet;

   sorted_list_scoreboard book = new();

   sorted_list_engine #(.CAPACITY(LIST_DEPTH)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_entry_count   (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result(rsp_status, rsp_popped_value, int'(rsp_entry_count));
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 6);
   end

   task automatic send_request(sle_code_type cmd, sle_value_type val);
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_operand_value <= val;
      do @(posedge clock); while (req_stall);
      book.note_request(cmd, val);
   endtask

   task automatic pause_requests(int cycles);
      req_valid         <= 1'b0;
      req_operand_value <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic sle_value_type pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 5))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return VALUE_MIN + 1;
            3: return VALUE_MAX - 1;
            4: return -1;
            default: return 0;
         endcase
      end
      if (sel < 5) return $signed($urandom_range(0, 16)) - 8;
      return $urandom;
   endfunction

   function automatic sle_code_type pick_command(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         0: return roll < 80 ? CMD_INSERT : roll < 90 ? CMD_SEARCH :
                   roll < 95 ? CMD_DELETE : CMD_POP;
         1: return roll < 15 ? CMD_INSERT : roll < 30 ? CMD_SEARCH :
                   roll < 65 ? CMD_DELETE : CMD_POP;
         default: return sle_code_type'(roll % 4);
      endcase
   endfunction

   initial begin
      sle_code_type  cmd;
      sle_value_type val;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_command       <= CMD_INSERT;
      req_operand_value <= '0;
      rsp_stall         <= 1'b0;
      quiet             <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_request(CMD_POP, 0);
      send_request(CMD_SEARCH, 0);
      send_request(CMD_DELETE, 5);
      send_request(CMD_INSERT, VALUE_MAX);
      send_request(CMD_INSERT, VALUE_MIN);
      send_request(CMD_INSERT, 0);
      send_request(CMD_INSERT, 0);
      send_request(CMD_INSERT, -1);
      send_request(CMD_INSERT, 1);
      send_request(CMD_SEARCH, VALUE_MIN);
      send_request(CMD_SEARCH, VALUE_MAX);
      send_request(CMD_SEARCH, 7);
      send_request(CMD_SEARCH, 0);
      send_request(CMD_DELETE, 0);
      send_request(CMD_DELETE, 0);
      send_request(CMD_DELETE, 0);
      send_request(CMD_POP, VALUE_MAX);
      send_request(CMD_POP, -1);
      send_request(CMD_POP, VALUE_MIN);
      send_request(CMD_POP, 0);
      send_request(CMD_POP, 0);

      for (int n = 0; n < 1830; n++) begin
         quiet <= (n >= 700 && n < 1100);
         if (!(n >= 700 && n < 1100) && $urandom_range(0, 99) < 6)
            pause_requests($urandom_range(1, 3));
         cmd = pick_command((n / 150) % 3);
         if ((cmd == CMD_SEARCH || cmd == CMD_DELETE) && book.held.size() != 0 &&
             $urandom_range(0, 9) < 6)
            val = book.held[$urandom_range(0, book.held.size() - 1)];
         else if (cmd == CMD_POP)
            val = $urandom;
         else
            val = pick_value();
         send_request(cmd, val);
      end

      req_valid <= 1'b0;
      while (book.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (book.errors == 0 && book.awaited.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
